// ===== hw/rtl/clock_alarm_setting_controller_core_macros.svh =====
// Assertion macros for the clock/alarm set controller checker.
`ifndef CLOCK_ALARM_SETTING_CONTROLLER_CORE_MACROS_SVH
`define CLOCK_ALARM_SETTING_CONTROLLER_CORE_MACROS_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define CASC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, also checked during reset.
`define CASC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/casc_pkg.sv =====
// Types, codes and BCD digit helpers for the clock/alarm set controller.
package casc_pkg;

  localparam int unsigned TimeW = 22;

  localparam logic [2:0] CursorMax = 3'd5;

  typedef enum logic [2:0] {
    CMD_SHOW   = 3'd0,
    CMD_ASET   = 3'd1,
    CMD_TSET   = 3'd2,
    CMD_TOGGLE = 3'd3,
    CMD_UP     = 3'd4,
    CMD_DOWN   = 3'd5,
    CMD_LEFT   = 3'd6,
    CMD_RIGHT  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_SHOW      = 2'd0,
    MODE_ALARM_SET = 2'd1,
    MODE_TIME_SET  = 2'd2,
    MODE_TOGGLE    = 2'd3
  } mode_e;

  typedef logic [TimeW-1:0] bcd_time_t;

  // Digit under the cursor, hours tens zero-extended.
  function automatic logic [3:0] get_digit(input bcd_time_t v, input logic [2:0] pos);
    logic [23:0] w;
    logic [3:0]  d;
    w = {2'b00, v};
    unique case (pos)
      3'd0:    d = w[3:0];
      3'd1:    d = w[7:4];
      3'd2:    d = w[11:8];
      3'd3:    d = w[15:12];
      3'd4:    d = w[19:16];
      3'd5:    d = w[23:20];
      default: d = 4'd0;
    endcase
    return d;
  endfunction

  // One-step increment within hh:mm:ss limits, no carry.
  function automatic bcd_time_t raise_digit(input bcd_time_t v, input logic [2:0] pos);
    logic [23:0] w;
    logic [3:0]  d;
    logic [3:0]  d5;
    logic [3:0]  d4;
    logic        ok;
    w  = {2'b00, v};
    d  = get_digit(v, pos);
    d5 = w[23:20];
    d4 = w[19:16];
    unique case (pos)
      3'd5:       ok = ((d5 < 4'd2) && (d4 < 4'd4)) || (d5 < 4'd1);
      3'd4:       ok = ((d4 < 4'd3) && (d5 <= 4'd2)) || ((d4 < 4'd9) && (d5 <= 4'd1));
      3'd3, 3'd1: ok = d < 4'd5;
      3'd2, 3'd0: ok = d < 4'd9;
      default:    ok = 1'b0;
    endcase
    if (ok) begin
      w = w + (24'd1 << {pos, 2'b00});
    end
    return w[TimeW-1:0];
  endfunction

  // One-step decrement of a nonzero digit, no borrow.
  function automatic bcd_time_t lower_digit(input bcd_time_t v, input logic [2:0] pos);
    logic [23:0] w;
    w = {2'b00, v};
    if ((pos <= CursorMax) && (get_digit(v, pos) != 4'd0)) begin
      w = w - (24'd1 << {pos, 2'b00});
    end
    return w[TimeW-1:0];
  endfunction

endpackage

// ===== hw/rtl/clock_alarm_setting_controller_core.sv =====
// Top level of the clock/alarm set controller.
//
// Clock/alarm set controller. Each input transaction (command_i, time_value_i)
// yields exactly one output transaction that reports the whole state after
// the command: clock and alarm time as packed BCD hhmmss, mode, alarm enable,
// digit cursor, entry mode, committed edit value and a key flag. The
// transaction is captured in an input register, then one pass of short BCD
// digit logic updates the state, and the state registers themselves form
// the result register. One transaction per cycle is sustained
// while out_stall_i stays low; a stall holds the result and, once the input
// register is full, back-pressures the input side through in_stall_o. Reset
// puts both times to 00:00:00, show mode, cursor 0, alarm off.
module clock_alarm_setting_controller_core
  import casc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [21:0] time_value_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [21:0] clock_now_o,
  output logic [21:0] alarm_now_o,
  output logic [1:0]  mode_now_o,
  output logic        alarm_enabled_o,
  output logic [2:0]  cursor_pos_o,
  output logic [1:0]  entry_mode_o,
  output logic [21:0] committed_value_o,
  output logic        key_notify_o
);

  // Input stage
  logic      in_vld_q;
  cmd_e      cmd_q;
  bcd_time_t tv_q;

  // State; it doubles as the result register
  logic      out_vld_q, out_vld_d;
  mode_e     mode_q, mode_d;
  logic [2:0] cursor_q, cursor_d;
  bcd_time_t edit_q, edit_d;
  bcd_time_t clock_q, clock_d;
  bcd_time_t alarm_q, alarm_d;
  logic      alarm_on_q, alarm_on_d;
  mode_e     entry_q, entry_d;
  bcd_time_t commit_q, commit_d;
  logic      notify_q, notify_d;

  logic advance;  // input stage moves into the result register
  logic in_take;

  // Result register may be refilled when empty or being drained.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_take || (in_vld_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_e'(command_i);
      tv_q  <= time_value_i;
    end
  end

  // Single-pass state update for the transaction in the input register
  always_comb begin
    mode_e prev;
    mode_d     = mode_q;
    cursor_d   = cursor_q;
    edit_d     = edit_q;
    clock_d    = clock_q;
    alarm_d    = alarm_q;
    alarm_on_d = alarm_on_q;
    entry_d    = entry_q;
    commit_d   = commit_q;
    notify_d   = notify_q;
    out_vld_d  = out_vld_q && out_stall_i;
    prev       = mode_q;

    if (advance) begin
      out_vld_d = 1'b1;
      notify_d  = (cmd_q != CMD_SHOW);

      // mode keys
      unique case (cmd_q)
        CMD_ASET:   mode_d = (prev == MODE_ALARM_SET) ? MODE_SHOW : MODE_ALARM_SET;
        CMD_TSET:   mode_d = (prev == MODE_TIME_SET) ? MODE_SHOW : MODE_TIME_SET;
        CMD_TOGGLE: begin
          mode_d     = MODE_TOGGLE;
          alarm_on_d = !alarm_on_q;
        end
        default:    mode_d = prev;
      endcase

      if (cmd_q == CMD_SHOW) begin
        if (prev != MODE_TIME_SET) begin
          clock_d = tv_q;
        end
      end else begin
        if (mode_d != prev) begin
          cursor_d = '0;
          if ((prev == MODE_TIME_SET) || (prev == MODE_ALARM_SET)) begin
            commit_d = edit_q;
          end
          if (!((mode_d == MODE_TIME_SET) || (mode_d == MODE_ALARM_SET))) begin
            entry_d = MODE_SHOW;
          end
        end

        if ((mode_d == MODE_TIME_SET) || (mode_d == MODE_ALARM_SET)) begin
          // entering a set mode loads the edit value from the target time
          if (prev != mode_d) begin
            edit_d = (mode_d == MODE_TIME_SET) ? clock_q : alarm_q;
          end
          unique case (cmd_q)
            CMD_LEFT:  if (cursor_d < CursorMax) cursor_d = cursor_d + 3'd1;
            CMD_RIGHT: if (cursor_d != 3'd0) cursor_d = cursor_d - 3'd1;
            CMD_UP:    edit_d = raise_digit(edit_d, cursor_d);
            CMD_DOWN:  edit_d = lower_digit(edit_d, cursor_d);
            default:   ;
          endcase
          // edits go live immediately
          if (mode_d == MODE_TIME_SET) begin
            clock_d = edit_d;
            entry_d = MODE_TIME_SET;
          end else begin
            alarm_d = edit_d;
            entry_d = MODE_ALARM_SET;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      mode_q     <= MODE_SHOW;
      cursor_q   <= '0;
      edit_q     <= '0;
      clock_q    <= '0;
      alarm_q    <= '0;
      alarm_on_q <= 1'b0;
      entry_q    <= MODE_SHOW;
      commit_q   <= '0;
      notify_q   <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      mode_q     <= mode_d;
      cursor_q   <= cursor_d;
      edit_q     <= edit_d;
      clock_q    <= clock_d;
      alarm_q    <= alarm_d;
      alarm_on_q <= alarm_on_d;
      entry_q    <= entry_d;
      commit_q   <= commit_d;
      notify_q   <= notify_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign clock_now_o       = clock_q;
  assign alarm_now_o       = alarm_q;
  assign mode_now_o        = mode_q;
  assign alarm_enabled_o   = alarm_on_q;
  assign cursor_pos_o      = cursor_q;
  assign entry_mode_o      = entry_q;
  assign committed_value_o = commit_q;
  assign key_notify_o      = notify_q;

endmodule

// ===== hw/rtl/casc_checker.sv =====
// Port-level checker for the clock/alarm set controller, with its bind.
`include "clock_alarm_setting_controller_core_macros.svh"

module casc_checker
  import casc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [21:0] clock_now_o,
  input logic [1:0]  mode_now_o,
  input logic [2:0]  cursor_pos_o,
  input logic [1:0]  entry_mode_o
);

  logic set_mode_active;

  assign set_mode_active = (mode_now_o == MODE_ALARM_SET) || (mode_now_o == MODE_TIME_SET);

  // stalled result holds
  `CASC_ASSERT(a_out_hold,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(clock_now_o)),
    "stalled result changed")

  `CASC_ASSERT_ALWAYS(a_cursor_range,
    out_valid_o |-> (cursor_pos_o <= CursorMax),
    "cursor beyond hours tens")

  // entry mode tracks the set mode, zero otherwise
  `CASC_ASSERT(a_entry_mode,
    out_valid_o |-> (set_mode_active ? (entry_mode_o == mode_now_o)
                                     : (entry_mode_o == MODE_SHOW)),
    "entry mode out of step with mode")

  // cursor only leaves zero inside a set mode
  `CASC_ASSERT(a_cursor_mode,
    (out_valid_o && (cursor_pos_o != 3'd0)) |-> set_mode_active,
    "cursor moved outside a set mode")

endmodule

bind clock_alarm_setting_controller_core casc_checker u_casc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .clock_now_o  (clock_now_o),
  .mode_now_o   (mode_now_o),
  .cursor_pos_o (cursor_pos_o),
  .entry_mode_o (entry_mode_o)
);

// ===== tb/clock_alarm_report_monitor.sv =====
// Transaction monitor for the clock/alarm set controller: predicts each report and checks it.
`timescale 1ns / 100ps

module clock_alarm_report_monitor
  import casc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [21:0] time_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [21:0] clock_now_i,
  input  logic [21:0] alarm_now_i,
  input  logic [1:0]  mode_now_i,
  input  logic        alarm_enabled_i,
  input  logic [2:0]  cursor_pos_i,
  input  logic [1:0]  entry_mode_i,
  input  logic [21:0] committed_value_i,
  input  logic        key_notify_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic [21:0] clock_now;
    logic [21:0] alarm_now;
    mode_e       mode;
    logic        alarm_en;
    logic [2:0]  cursor;
    mode_e       entry;
    logic [21:0] committed;
    logic        notify;
  } panel_report_t;

  // predicted panel state, BCD times kept at 24 bits
  mode_e       mode_q;
  mode_e       entry_q;
  logic [2:0]  cursor_q;
  logic [23:0] edit_q;
  logic [23:0] clock_q;
  logic [23:0] alarm_q;
  logic [23:0] commit_q;
  logic        alarm_on_q;

  panel_report_t expected_reports[$];
  int err_cnt;
  int chk_cnt;

  function automatic logic [3:0] digit_at(logic [23:0] v, logic [2:0] pos);
    return v[pos*4 +: 4];
  endfunction

  function automatic bit is_set_mode(mode_e m);
    return (m == MODE_TIME_SET) || (m == MODE_ALARM_SET);
  endfunction

  // Advance the panel state by one command and queue the report it produces.
  function automatic void apply_command(cmd_e cmd, logic [21:0] tv);
    mode_e         prev;
    logic [3:0]    dig;
    logic [3:0]    hr_tens;
    logic [3:0]    hr_units;
    logic          can_raise;
    panel_report_t rpt;
    prev = mode_q;
    if (cmd == CMD_SHOW) begin
      if (mode_q != MODE_TIME_SET) clock_q = {2'b00, tv};
    end else begin
      case (cmd)
        CMD_ASET:   mode_q = (prev == MODE_ALARM_SET) ? MODE_SHOW : MODE_ALARM_SET;
        CMD_TSET:   mode_q = (prev == MODE_TIME_SET) ? MODE_SHOW : MODE_TIME_SET;
        CMD_TOGGLE: begin
          mode_q     = MODE_TOGGLE;
          alarm_on_q = ~alarm_on_q;
        end
        default: ;
      endcase
      if (mode_q != prev) begin
        cursor_q = 3'd0;
        if (is_set_mode(prev)) commit_q = edit_q;
        if (!is_set_mode(mode_q)) entry_q = MODE_SHOW;
      end
      if (is_set_mode(mode_q)) begin
        if (mode_q != prev) edit_q = (mode_q == MODE_TIME_SET) ? clock_q : alarm_q;
        dig      = digit_at(edit_q, cursor_q);
        hr_tens  = edit_q[23:20];
        hr_units = edit_q[19:16];
        case (cmd)
          CMD_LEFT:  if (cursor_q < CursorMax) cursor_q = cursor_q + 3'd1;
          CMD_RIGHT: if (cursor_q != 3'd0) cursor_q = cursor_q - 3'd1;
          CMD_UP: begin
            case (cursor_q)
              3'd5:       can_raise = (hr_tens < 2 && hr_units < 4) || hr_tens < 1;
              3'd4:       can_raise = (hr_units < 3 && hr_tens <= 2) ||
                                      (hr_units < 9 && hr_tens <= 1);
              3'd3, 3'd1: can_raise = dig < 5;
              3'd2, 3'd0: can_raise = dig < 9;
              default:    can_raise = 1'b0;
            endcase
            if (can_raise) edit_q = edit_q + (24'd1 << (cursor_q * 4));
          end
          CMD_DOWN:  if (dig != 4'd0) edit_q = edit_q - (24'd1 << (cursor_q * 4));
          default: ;
        endcase
        if (mode_q == MODE_TIME_SET) begin
          clock_q = edit_q;
          entry_q = MODE_TIME_SET;
        end else begin
          alarm_q = edit_q;
          entry_q = MODE_ALARM_SET;
        end
      end
    end
    rpt.clock_now = clock_q[21:0];
    rpt.alarm_now = alarm_q[21:0];
    rpt.mode      = mode_q;
    rpt.alarm_en  = alarm_on_q;
    rpt.cursor    = cursor_q;
    rpt.entry     = entry_q;
    rpt.committed = commit_q[21:0];
    rpt.notify    = (cmd != CMD_SHOW);
    expected_reports.push_back(rpt);
  endfunction

  function automatic int field_bad(string name, logic [21:0] want, logic [21:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    panel_report_t want;
    if (!rst_ni) begin
      mode_q     = MODE_SHOW;
      entry_q    = MODE_SHOW;
      cursor_q   = 3'd0;
      edit_q     = '0;
      clock_q    = '0;
      alarm_q    = '0;
      commit_q   = '0;
      alarm_on_q = 1'b0;
      expected_reports.delete();
      err_cnt    = 0;
      chk_cnt    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) apply_command(cmd_e'(command_i), time_value_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report with no command pending: expected none, got clock 0x%0h",
                   $time, clock_now_i);
          err_cnt++;
        end else begin
          want = expected_reports.pop_front();
          chk_cnt++;
          err_cnt += field_bad("clock_now", want.clock_now, clock_now_i);
          err_cnt += field_bad("alarm_now", want.alarm_now, alarm_now_i);
          err_cnt += field_bad("mode_now", want.mode, mode_now_i);
          err_cnt += field_bad("alarm_enabled", want.alarm_en, alarm_enabled_i);
          err_cnt += field_bad("cursor_pos", want.cursor, cursor_pos_i);
          err_cnt += field_bad("entry_mode", want.entry, entry_mode_i);
          err_cnt += field_bad("committed_value", want.committed, committed_value_i);
          err_cnt += field_bad("key_notify", want.notify, key_notify_i);
        end
      end
    end
    errors_o  <= err_cnt;
    pending_o <= expected_reports.size();
    checked_o <= chk_cnt;
  end

endmodule

// ===== tb/tb_top.sv =====
// Top-level testbench for the clock/alarm set controller: stimulus, throttling and verdict.
`timescale 1ns / 100ps

module tb_top;
  import casc_pkg::*;

  // number of random transactions spread over the four throttle phases
  localparam int RandomItems = 650;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  cmd_e        command;
  logic [21:0] time_value;
  logic        out_valid;
  logic        out_stall;
  logic [21:0] clock_now;
  logic [21:0] alarm_now;
  logic [1:0]  mode_now;
  logic        alarm_enabled;
  logic [2:0]  cursor_pos;
  logic [1:0]  entry_mode;
  logic [21:0] committed_value;
  logic        key_notify;

  int errors;
  int pending;
  int checked;

  // throttle knobs, percent of cycles
  int unsigned idle_pct;
  int unsigned stall_pct;

  // bookkeeping for the closing summary
  int sent;
  int directed_cnt;
  int edit_seqs;
  int noise_bursts;

  clock_alarm_setting_controller_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .time_value_i     (time_value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .clock_now_o      (clock_now),
    .alarm_now_o      (alarm_now),
    .mode_now_o       (mode_now),
    .alarm_enabled_o  (alarm_enabled),
    .cursor_pos_o     (cursor_pos),
    .entry_mode_o     (entry_mode),
    .committed_value_o(committed_value),
    .key_notify_o     (key_notify)
  );

  clock_alarm_report_monitor report_mon (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .command_i        (command),
    .time_value_i     (time_value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .clock_now_i      (clock_now),
    .alarm_now_i      (alarm_now),
    .mode_now_i       (mode_now),
    .alarm_enabled_i  (alarm_enabled),
    .cursor_pos_i     (cursor_pos),
    .entry_mode_i     (entry_mode),
    .committed_value_i(committed_value),
    .key_notify_i     (key_notify),
    .errors_o         (errors),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver side: stall at random, redrawn every cycle from the current knob.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Mostly legal hh:mm:ss times; the rest raw values from 0 up to 0x235959,
  // which brings in invalid BCD nibbles and exercises every bit.
  function automatic logic [21:0] rand_time();
    int unsigned hh;
    int unsigned mm;
    int unsigned ss;
    if ($urandom_range(0, 3) == 0) return 22'($urandom_range(0, 2316633));
    hh = $urandom_range(0, 23);
    mm = $urandom_range(0, 59);
    ss = $urandom_range(0, 59);
    return {2'(hh / 10), 4'(hh % 10), 4'(mm / 10), 4'(mm % 10), 4'(ss / 10), 4'(ss % 10)};
  endfunction

  // Present one transaction and return at the edge where it is taken.
  // Valid is left high on return so back-to-back transactions need no
  // second assignment in the same step; gaps lower it first.
  task automatic drive_command(cmd_e cmd, logic [21:0] tv);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    time_value <= tv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Pressure point: drop valid and hold off until every report is back.
  // It steps past a clock edge first so the pending count includes the last transaction.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Well-formed edit: enter a set mode, move and change digits with random
  // content, then leave it -- usually by the same key, sometimes by
  // switching modes or toggling the alarm straight out of the edit.
  task automatic edit_sequence();
    cmd_e key;
    cmd_e c;
    int   n;
    if ($urandom_range(0, 2) == 0) drive_command(CMD_SHOW, rand_time());
    key = $urandom_range(0, 1) ? CMD_TSET : CMD_ASET;
    drive_command(key, rand_time());
    n = $urandom_range(2, 16);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: c = CMD_UP;
        3, 4:    c = CMD_DOWN;
        5, 6, 7: c = CMD_LEFT;
        8:       c = CMD_RIGHT;
        default: c = CMD_SHOW;   // ignored for the clock while time set is open
      endcase
      drive_command(c, rand_time());
    end
    case ($urandom_range(0, 9))
      0:       c = CMD_TOGGLE;
      1:       c = (key == CMD_TSET) ? CMD_ASET : CMD_TSET;
      default: c = key;
    endcase
    drive_command(c, rand_time());
    edit_seqs++;
  endtask

  // Noise: any command in any mode, including arrows with no set mode open.
  task automatic noise_burst();
    repeat ($urandom_range(1, 3)) drive_command(cmd_e'($urandom_range(0, 7)), rand_time());
    noise_bursts++;
  endtask

  // Run-time guard, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int phase_end;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    command    <= CMD_SHOW;
    time_value <= '0;
    idle_pct     = 0;
    stall_pct    = 0;
    sent         = 0;
    edit_seqs    = 0;
    noise_bursts = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: field extremes, every command, the corner cases ----
    drive_command(CMD_SHOW, 22'h235959);        // latest legal time
    drive_command(CMD_UP, rand_time());         // arrow outside a set mode: notify only
    drive_command(CMD_TSET, rand_time());       // enter time set, edit loads 23:59:59
    drive_command(CMD_UP, rand_time());         // seconds units at 9 stays
    drive_command(CMD_RIGHT, rand_time());      // cursor already at 0
    repeat (6) drive_command(CMD_LEFT, rand_time());  // walk to hours tens, one past the end
    drive_command(CMD_UP, rand_time());         // hours tens 2 stays
    drive_command(CMD_DOWN, rand_time());       // 2 -> 1
    drive_command(CMD_UP, rand_time());         // 1 with units 3 -> 2
    repeat (3) drive_command(CMD_DOWN, rand_time());  // down to 0, then no wrap
    drive_command(CMD_SHOW, 22'h012345);        // ignored while time set is open
    drive_command(CMD_TSET, 22'h000000);        // leave: commit
    drive_command(CMD_SHOW, 22'h1FFFFF);        // invalid nibbles stored raw
    drive_command(CMD_ASET, rand_time());       // enter alarm set
    drive_command(CMD_TSET, rand_time());       // switch straight to time set
    drive_command(CMD_UP, rand_time());         // invalid nibble: up leaves it
    drive_command(CMD_DOWN, rand_time());       // invalid nibble: down lowers it
    drive_command(CMD_TOGGLE, rand_time());     // toggle out of an edit
    drive_command(CMD_TOGGLE, rand_time());     // toggle while toggled
    directed_cnt = sent;
    drain();

    // ---- random: four throttle phases, drained between them ----
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 50; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      phase_end = directed_cnt + (RandomItems * (phase + 1)) / 4;
      while (sent < phase_end) begin
        if ($urandom_range(0, 4) != 0) edit_sequence();
        else noise_burst();
      end
      drain();
    end

    // let the pipeline settle so a stray extra report would still be seen
    stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("Summary: %0d transactions (%0d directed, %0d edit sequences, %0d noise bursts)",
             sent, directed_cnt, edit_seqs, noise_bursts);
    $display("Summary: %0d reports checked under four throttle phases", checked);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
